/* design/pihc_pkg.sv */
// Shared types and constants for the padded interval hit counter.
// Used by pihc_head, pihc_cell and padded_interval_hit_counter_top; no dependencies.
`timescale 1ns / 1ps

package pihc_pkg;

    // Field widths fixed by the command and result beats
    localparam int FIELD_BITS = 32;
    localparam int ENTRY_BITS = 10;
    localparam int PAD_BITS   = 20;

    // Defaults for the top-level parameters
    localparam int MAX_INTERVALS_DEF = 1024;
    localparam int COORD_BITS_DEF    = 32;
    localparam int COUNT_BITS_DEF    = 32;

    // Command codes
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_COUNT  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // Input beat
    typedef struct packed {
        t_cmd                  command;
        logic [FIELD_BITS-1:0] interval_start;
        logic [FIELD_BITS-1:0] interval_end;
        logic [FIELD_BITS-1:0] read_position;
        logic [ENTRY_BITS-1:0] entry_index;
    } t_cmd_beat;

    // Result beat
    typedef struct packed {
        logic [FIELD_BITS-1:0] entry_start;
        logic [FIELD_BITS-1:0] entry_end;
        logic [FIELD_BITS-1:0] hit_total;
        logic                  entry_valid;
        logic                  table_overflow;
    } t_result_beat;

    // Control part of the token that walks down the cell chain
    typedef struct packed {
        logic vld;       // token carries a command
        t_cmd cmd;
        logic entry_ok;  // read index below the fill level at issue
        logic ovf;       // overflow flag at issue
    } t_tok_ctl;

endpackage

/* design/pihc_head.sv */
// Command head of the padded interval hit counter: fill level, overflow flag,
// padding register, and the token launched into the cell chain. Uses pihc_pkg.
`timescale 1ns / 1ps

module pihc_head #(
    parameter int MAX_INTERVALS = pihc_pkg::MAX_INTERVALS_DEF,
    parameter int COORD_BITS    = pihc_pkg::COORD_BITS_DEF,
    parameter int FILL_BITS     = $clog2(MAX_INTERVALS + 1),
    parameter int KEY_BITS      = COORD_BITS + 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  pihc_pkg::t_cmd_beat               i_cmd,
    input  logic                              i_cfg_we,
    input  logic [pihc_pkg::PAD_BITS-1:0]     i_cfg_wdata,
    output logic                              o_busy,
    output pihc_pkg::t_tok_ctl                o_ctl,
    output logic [KEY_BITS-1:0]               o_key_a,
    output logic [KEY_BITS-1:0]               o_key_b,
    output logic [pihc_pkg::ENTRY_BITS-1:0]   o_idx,
    output logic [FILL_BITS-1:0]              o_fill
);

    localparam int IW = (pihc_pkg::ENTRY_BITS > FILL_BITS) ? pihc_pkg::ENTRY_BITS : FILL_BITS;

    logic                            r_ready;
    logic [pihc_pkg::PAD_BITS-1:0]   r_pad;
    logic [FILL_BITS-1:0]            r_fill, n_fill;
    logic                            r_ovf, n_ovf;
    pihc_pkg::t_tok_ctl              r_ctl, n_ctl;
    logic [KEY_BITS-1:0]             r_key_a, n_key_a;
    logic [KEY_BITS-1:0]             r_key_b, n_key_b;
    logic [pihc_pkg::ENTRY_BITS-1:0] r_idx;
    logic [FILL_BITS-1:0]            r_fill_tok;

    logic                  accept;
    logic                  full;
    logic [KEY_BITS-1:0]   pos_k;
    logic [KEY_BITS-1:0]   pad_k;

    assign accept = i_start && r_ready;
    assign full   = (r_fill == FILL_BITS'(MAX_INTERVALS));
    assign pos_k  = KEY_BITS'(COORD_BITS'(i_cmd.read_position));
    assign pad_k  = KEY_BITS'(r_pad);

    // Update table bookkeeping and build the outgoing token
    always_comb begin
        n_fill  = r_fill;
        n_ovf   = r_ovf;
        n_key_a = '0;
        n_key_b = '0;
        case (i_cmd.command)
            pihc_pkg::CMD_CLEAR: begin
                if (accept) begin
                    n_fill = '0;
                    n_ovf  = 1'b0;
                end
            end
            pihc_pkg::CMD_APPEND: begin
                n_key_a = KEY_BITS'(COORD_BITS'(i_cmd.interval_start));
                n_key_b = KEY_BITS'(COORD_BITS'(i_cmd.interval_end));
                if (accept) begin
                    if (!full) begin
                        n_fill = r_fill + FILL_BITS'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            pihc_pkg::CMD_COUNT: begin
                // padded window test becomes start <= pos+pad and end >= pos-pad
                n_key_a = pos_k + pad_k;
                n_key_b = pos_k - pad_k;
            end
            default: begin
            end
        endcase
        n_ctl.vld      = accept;
        n_ctl.cmd      = i_cmd.command;
        n_ctl.entry_ok = (IW'(i_cmd.entry_index) < IW'(r_fill));
        n_ctl.ovf      = r_ovf;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_pad   <= '0;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_ctl   <= '0;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_we) begin
                r_pad <= i_cfg_wdata;
            end
            r_fill <= n_fill;
            r_ovf  <= n_ovf;
            r_ctl  <= n_ctl;
        end
    end

    // Token payload
    always_ff @(posedge i_clk) begin
        r_key_a    <= n_key_a;
        r_key_b    <= n_key_b;
        r_idx      <= i_cmd.entry_index;
        r_fill_tok <= r_fill;
    end

    assign o_busy  = !r_ready;
    assign o_ctl   = r_ctl;
    assign o_key_a = r_key_a;
    assign o_key_b = r_key_b;
    assign o_idx   = r_idx;
    assign o_fill  = r_fill_tok;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_BITS'(MAX_INTERVALS))
        else $error("fill level beyond table size");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.command == pihc_pkg::CMD_CLEAR |=> r_fill == '0 && !r_ovf)
        else $error("clear did not empty the table");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.command == pihc_pkg::CMD_APPEND && full |=> r_ovf && $stable(r_fill))
        else $error("append to full table not dropped");
`endif

endmodule

/* design/pihc_cell.sv */
// One interval cell: holds start, end and hit count of one table entry and
// acts on each token as it passes to the next cell. Uses pihc_pkg.
`timescale 1ns / 1ps

module pihc_cell #(
    parameter int CELL_INDEX = 0,
    parameter int COORD_BITS = pihc_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = pihc_pkg::COUNT_BITS_DEF,
    parameter int FILL_BITS  = 11,
    parameter int KEY_BITS   = COORD_BITS + 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pihc_pkg::t_tok_ctl              i_ctl,
    input  logic [KEY_BITS-1:0]             i_key_a,
    input  logic [KEY_BITS-1:0]             i_key_b,
    input  logic [COUNT_BITS-1:0]           i_hit,
    input  logic [pihc_pkg::ENTRY_BITS-1:0] i_idx,
    input  logic [FILL_BITS-1:0]            i_fill,
    output pihc_pkg::t_tok_ctl              o_ctl,
    output logic [KEY_BITS-1:0]             o_key_a,
    output logic [KEY_BITS-1:0]             o_key_b,
    output logic [COUNT_BITS-1:0]           o_hit,
    output logic [pihc_pkg::ENTRY_BITS-1:0] o_idx,
    output logic [FILL_BITS-1:0]            o_fill
);

    localparam int IW = (pihc_pkg::ENTRY_BITS > FILL_BITS) ? pihc_pkg::ENTRY_BITS : FILL_BITS;

    // Entry state
    logic [COORD_BITS-1:0] r_start, n_start;
    logic [COORD_BITS-1:0] r_end, n_end;
    logic [COUNT_BITS-1:0] r_hit, n_hit;

    // Token toward the next cell
    pihc_pkg::t_tok_ctl              r_ctl;
    logic [KEY_BITS-1:0]             r_key_a, n_key_a;
    logic [KEY_BITS-1:0]             r_key_b, n_key_b;
    logic [COUNT_BITS-1:0]           r_hit_tok, n_hit_tok;
    logic [pihc_pkg::ENTRY_BITS-1:0] r_idx;
    logic [FILL_BITS-1:0]            r_fill;

    logic                loaded;
    logic                own_slot;
    logic                selected;
    logic                in_window;
    logic [KEY_BITS-1:0] start_k;
    logic [KEY_BITS-1:0] end_k;

    assign loaded    = (FILL_BITS'(CELL_INDEX) < i_fill);
    assign own_slot  = (i_fill == FILL_BITS'(CELL_INDEX));
    assign selected  = (IW'(i_idx) == IW'(CELL_INDEX));
    assign start_k   = KEY_BITS'(r_start);
    assign end_k     = KEY_BITS'(r_end);
    assign in_window = ($signed(start_k) <= $signed(i_key_a))
                    && ($signed(end_k) >= $signed(i_key_b));

    // Act on the passing token
    always_comb begin
        n_start   = r_start;
        n_end     = r_end;
        n_hit     = r_hit;
        n_key_a   = i_key_a;
        n_key_b   = i_key_b;
        n_hit_tok = i_hit;
        if (i_ctl.vld) begin
            case (i_ctl.cmd)
                pihc_pkg::CMD_APPEND: begin
                    if (own_slot) begin
                        n_start = i_key_a[COORD_BITS-1:0];
                        n_end   = i_key_b[COORD_BITS-1:0];
                        n_hit   = '0;
                    end
                end
                pihc_pkg::CMD_COUNT: begin
                    // saturate at all ones
                    if (loaded && in_window && (r_hit != '1)) begin
                        n_hit = r_hit + COUNT_BITS'(1);
                    end
                end
                pihc_pkg::CMD_READ: begin
                    if (selected && i_ctl.entry_ok) begin
                        n_key_a   = start_k;
                        n_key_b   = end_k;
                        n_hit_tok = r_hit;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Advance token control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Entry state and token payload
    always_ff @(posedge i_clk) begin
        r_start   <= n_start;
        r_end     <= n_end;
        r_hit     <= n_hit;
        r_key_a   <= n_key_a;
        r_key_b   <= n_key_b;
        r_hit_tok <= n_hit_tok;
        r_idx     <= i_idx;
        r_fill    <= i_fill;
    end

    assign o_ctl   = r_ctl;
    assign o_key_a = r_key_a;
    assign o_key_b = r_key_b;
    assign o_hit   = r_hit_tok;
    assign o_idx   = r_idx;
    assign o_fill  = r_fill;

endmodule

/* design/padded_interval_hit_counter_top.sv */
// Top level of the padded interval hit counter: command head, chain of
// interval cells, result strobe. Uses pihc_pkg, pihc_head and pihc_cell.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive i_cmd and raise i_start; the beat is taken at a
//   rising edge with i_start high and o_busy low. Commands are clear, append,
//   count a read position, and read one entry.
//   Config: i_cfg_we with i_cfg_wdata writes the 20-bit window padding; write
//   it only while no command is in flight.
//   Result channel: a read produces one beat on o_result, flagged by o_done
//   for exactly one cycle; it must be taken then, there is no back-pressure.
//   Clear, append and count produce no beat.
// Timing
//   Each command becomes a token that steps through MAX_INTERVALS cells, one
//   cell per cycle. o_done for a read rises when its token, registered in the
//   head and then in each cell, leaves the last cell; the beat is taken at
//   the edge after that. One command is taken per cycle while o_busy is low;
//   results leave in command order.
// Reset
//   Synchronous, active low. Empties the table, clears the overflow flag and
//   padding, and drops tokens in flight; o_busy is high for one cycle after.
module padded_interval_hit_counter_top #(
    parameter int MAX_INTERVALS = pihc_pkg::MAX_INTERVALS_DEF,
    parameter int COORD_BITS    = pihc_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS    = pihc_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  pihc_pkg::t_cmd_beat           i_cmd,
    output logic                          o_busy,
    input  logic                          i_cfg_we,
    input  logic [pihc_pkg::PAD_BITS-1:0] i_cfg_wdata,
    output logic                          o_done,
    output pihc_pkg::t_result_beat        o_result
);

    localparam int FILL_BITS = $clog2(MAX_INTERVALS + 1);
    localparam int WIDE_BITS = (COORD_BITS > pihc_pkg::PAD_BITS) ? COORD_BITS
                                                                 : pihc_pkg::PAD_BITS;
    localparam int KEY_BITS  = WIDE_BITS + 2;
    localparam int FW        = pihc_pkg::FIELD_BITS;

    pihc_pkg::t_tok_ctl              chain_ctl   [MAX_INTERVALS+1];
    logic [KEY_BITS-1:0]             chain_key_a [MAX_INTERVALS+1];
    logic [KEY_BITS-1:0]             chain_key_b [MAX_INTERVALS+1];
    logic [COUNT_BITS-1:0]           chain_hit   [MAX_INTERVALS+1];
    logic [pihc_pkg::ENTRY_BITS-1:0] chain_idx   [MAX_INTERVALS+1];
    logic [FILL_BITS-1:0]            chain_fill  [MAX_INTERVALS+1];

    pihc_pkg::t_tok_ctl    tail_ctl;
    logic [KEY_BITS-1:0]   tail_key_a;
    logic [KEY_BITS-1:0]   tail_key_b;
    logic [COUNT_BITS-1:0] tail_hit;

    // Launch tokens
    pihc_head #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .COORD_BITS    (COORD_BITS),
        .FILL_BITS     (FILL_BITS),
        .KEY_BITS      (KEY_BITS)
    ) u_head (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_busy      (o_busy),
        .o_ctl       (chain_ctl[0]),
        .o_key_a     (chain_key_a[0]),
        .o_key_b     (chain_key_b[0]),
        .o_idx       (chain_idx[0]),
        .o_fill      (chain_fill[0])
    );

    // Read results collect their hit count along the chain
    assign chain_hit[0] = '0;

    // Row of interval cells
    for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
        pihc_cell #(
            .CELL_INDEX (g),
            .COORD_BITS (COORD_BITS),
            .COUNT_BITS (COUNT_BITS),
            .FILL_BITS  (FILL_BITS),
            .KEY_BITS   (KEY_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (chain_ctl[g]),
            .i_key_a (chain_key_a[g]),
            .i_key_b (chain_key_b[g]),
            .i_hit   (chain_hit[g]),
            .i_idx   (chain_idx[g]),
            .i_fill  (chain_fill[g]),
            .o_ctl   (chain_ctl[g+1]),
            .o_key_a (chain_key_a[g+1]),
            .o_key_b (chain_key_b[g+1]),
            .o_hit   (chain_hit[g+1]),
            .o_idx   (chain_idx[g+1]),
            .o_fill  (chain_fill[g+1])
        );
    end

    assign tail_ctl   = chain_ctl[MAX_INTERVALS];
    assign tail_key_a = chain_key_a[MAX_INTERVALS];
    assign tail_key_b = chain_key_b[MAX_INTERVALS];
    assign tail_hit   = chain_hit[MAX_INTERVALS];

    // Strobe read results off the end of the chain
    assign o_done                  = tail_ctl.vld && (tail_ctl.cmd == pihc_pkg::CMD_READ);
    assign o_result.entry_start    = FW'(tail_key_a[COORD_BITS-1:0]);
    assign o_result.entry_end      = FW'(tail_key_b[COORD_BITS-1:0]);
    assign o_result.hit_total      = FW'(tail_hit);
    assign o_result.entry_valid    = tail_ctl.entry_ok;
    assign o_result.table_overflow = tail_ctl.ovf;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.entry_valid |->
            o_result.entry_start == '0 && o_result.entry_end == '0
            && o_result.hit_total == '0)
        else $error("invalid entry reported with nonzero fields");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for padded_interval_hit_counter_top: table commands, padding and reads.
// Depends on pihc_pkg and the design sources; reads no files and needs no arguments.
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_DEPTH = pihc_pkg::MAX_INTERVALS_DEF;
    localparam int ENTRY_W = pihc_pkg::ENTRY_BITS;
    localparam int PAD_W = pihc_pkg::PAD_BITS;
    localparam int READ_LATENCY = TABLE_DEPTH + 1;
    localparam int DRAIN_CYCLES = READ_LATENCY + 16;
    localparam int RAND_PHASES = 5;
    localparam int RAND_PER_PHASE = 172;
    localparam longint RUN_LIMIT_NS = 2_000_000;
    localparam bit [PAD_W-1:0] PAD_MAX = {PAD_W{1'b1}};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_start = 1'b0;
    pihc_pkg::t_cmd_beat    i_cmd = '0;
    logic                   o_busy;
    logic                   i_cfg_we = 1'b0;
    logic [PAD_W-1:0]       i_cfg_wdata = '0;
    logic                   o_done;
    pihc_pkg::t_result_beat o_result;

    padded_interval_hit_counter_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .o_busy      (o_busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    // Generate the 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the interval table
    bit [31:0]      shadow_start [TABLE_DEPTH];
    bit [31:0]      shadow_end   [TABLE_DEPTH];
    bit [31:0]      shadow_hits  [TABLE_DEPTH];
    int unsigned    shadow_fill;
    bit             shadow_ovf;
    bit [PAD_W-1:0] shadow_pad;

    pihc_pkg::t_result_beat pending_reads [$];

    int unsigned beats_sent;
    int unsigned reads_checked;
    int unsigned valid_reads;
    int unsigned ovf_reads;
    int unsigned mismatches;
    int unsigned pad_writes;

    // Burst pacing of the command side
    int unsigned burst_left;
    bit          gaps_on;

    // Apply one accepted command to the shadow table; queue the read result
    function automatic void track_command(pihc_pkg::t_cmd_beat b);
        pihc_pkg::t_result_beat r;
        longint                 pos, lo, hi;
        int unsigned            idx;
        case (b.command)
            pihc_pkg::CMD_CLEAR: begin
                shadow_fill = 0;
                shadow_ovf  = 1'b0;
            end
            pihc_pkg::CMD_APPEND: begin
                if (shadow_fill < TABLE_DEPTH) begin
                    shadow_start[shadow_fill] = b.interval_start;
                    shadow_end[shadow_fill]   = b.interval_end;
                    shadow_hits[shadow_fill]  = '0;
                    shadow_fill++;
                end else begin
                    shadow_ovf = 1'b1;
                end
            end
            pihc_pkg::CMD_COUNT: begin
                // Widen each interval by the padding in signed 64-bit terms
                pos = longint'({32'd0, b.read_position});
                for (int n = 0; n < shadow_fill; n++) begin
                    lo = longint'({32'd0, shadow_start[n]}) - longint'(shadow_pad);
                    hi = longint'({32'd0, shadow_end[n]}) + longint'(shadow_pad);
                    if (pos >= lo && pos <= hi && shadow_hits[n] != 32'hFFFF_FFFF)
                        shadow_hits[n]++;
                end
            end
            default: begin
                idx = 32'(b.entry_index);
                r = '0;
                if (idx < shadow_fill) begin
                    r.entry_start = shadow_start[idx];
                    r.entry_end   = shadow_end[idx];
                    r.hit_total   = shadow_hits[idx];
                    r.entry_valid = 1'b1;
                end
                r.table_overflow = shadow_ovf;
                pending_reads = {pending_reads, r};
            end
        endcase
    endfunction

    // Random filler for every field; callers override what the command uses
    function automatic pihc_pkg::t_cmd_beat noise_beat();
        pihc_pkg::t_cmd_beat b;
        b.command        = pihc_pkg::t_cmd'($urandom_range(0, 3));
        b.interval_start = $urandom;
        b.interval_end   = $urandom;
        b.read_position  = $urandom;
        b.entry_index    = ENTRY_W'($urandom_range(0, TABLE_DEPTH - 1));
        return b;
    endfunction

    // Drive one beat and hold it until the block takes it
    task automatic send_beat(pihc_pkg::t_cmd_beat b);
        i_cmd   <= b;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        track_command(b);
        beats_sent++;
    endtask

    // Drop start for a random gap at the end of each burst
    task automatic pace();
        if (!gaps_on)
            return;
        if (burst_left == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
    endtask

    task automatic do_clear();
        pihc_pkg::t_cmd_beat b;
        b = noise_beat();
        b.command = pihc_pkg::CMD_CLEAR;
        send_beat(b);
    endtask

    task automatic do_append(bit [31:0] s, bit [31:0] e);
        pihc_pkg::t_cmd_beat b;
        b = noise_beat();
        b.command        = pihc_pkg::CMD_APPEND;
        b.interval_start = s;
        b.interval_end   = e;
        send_beat(b);
    endtask

    task automatic do_count(bit [31:0] p);
        pihc_pkg::t_cmd_beat b;
        b = noise_beat();
        b.command       = pihc_pkg::CMD_COUNT;
        b.read_position = p;
        send_beat(b);
    endtask

    task automatic do_read(bit [ENTRY_W-1:0] idx);
        pihc_pkg::t_cmd_beat b;
        b = noise_beat();
        b.command     = pihc_pkg::CMD_READ;
        b.entry_index = idx;
        send_beat(b);
    endtask

    // Wait for every queued read, then let any count or append finish its walk
    task automatic wait_idle();
        i_start <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_padding(bit [PAD_W-1:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        shadow_pad = v;
        pad_writes++;
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Check each result beat against the oldest queued read
    always @(posedge i_clk) begin : check_results
        pihc_pkg::t_result_beat want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat with no read pending: got %p", o_result);
            end else begin
                want = pending_reads.pop_front();
                reads_checked++;
                if (want.entry_valid)
                    valid_reads++;
                if (want.table_overflow)
                    ovf_reads++;
                if (o_result.entry_start !== want.entry_start ||
                        o_result.entry_end !== want.entry_end ||
                        o_result.hit_total !== want.hit_total ||
                        o_result.entry_valid !== want.entry_valid ||
                        o_result.table_overflow !== want.table_overflow) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: read mismatch at %0t", $realtime);
                        $display("  start exp %h got %h, end exp %h got %h",
                                 want.entry_start, o_result.entry_start,
                                 want.entry_end, o_result.entry_end);
                        $display("  hits exp %h got %h, valid exp %b got %b, ovf exp %b got %b",
                                 want.hit_total, o_result.hit_total,
                                 want.entry_valid, o_result.entry_valid,
                                 want.table_overflow, o_result.table_overflow);
                    end
                end
            end
        end
    end

    // Empty table reads, edge coordinates, reversed interval, zero padding
    task automatic test_directed();
        do_read(0);
        do_read(10'h3FF);
        do_clear();
        do_append(32'h0000_0000, 32'h0000_0000);
        do_append(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        do_append(32'd100, 32'd200);
        do_append(32'd500, 32'd400);
        do_append(32'h0000_0000, 32'hFFFF_FFFF);
        do_append(32'd1000, 32'd1000);
        do_count(32'h0000_0000);
        do_count(32'hFFFF_FFFF);
        do_count(32'd100);
        do_count(32'd200);
        do_count(32'd99);
        do_count(32'd201);
        do_count(32'd450);
        do_count(32'd1000);
        for (int i = 0; i < 7; i++)
            do_read(i[ENTRY_W-1:0]);
        do_read(10'h3FF);
    endtask

    // Widest padding: start minus padding below zero, end plus padding past 32 bits; then a padding of one
    task automatic test_padding_edges();
        write_padding(PAD_MAX);
        do_clear();
        do_append(32'd5, 32'd10);
        do_append(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        do_append(32'h0030_0000, 32'h0000_0000);
        do_append(32'h0020_0000, 32'h0020_0000);
        do_count(32'h0000_0000);
        do_count(32'hFFFF_FFFF);
        do_count(32'h0010_0009);
        do_count(32'h0010_000A);
        do_count(32'h0010_0001);
        do_count(32'h0030_0000);
        do_count(32'h0030_0001);
        do_count(32'hFFEF_FFF0);
        do_count(32'hFFEF_FFEF);
        for (int i = 0; i < 4; i++)
            do_read(i[ENTRY_W-1:0]);
        write_padding(20'd1);
        do_count(32'd4);
        do_count(32'd11);
        do_count(32'd3);
        do_read(0);
    endtask

    // Fill every entry, overflow the table, then clear the sticky flag
    task automatic test_full_table();
        bit [31:0] s;
        write_padding(20'd3);
        gaps_on = 1'b1;
        do_clear();
        pace();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            s = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 65535);
            do_append(s, ($urandom_range(0, 7) == 0) ? $urandom : s + $urandom_range(0, 300));
            pace();
        end
        for (int i = 0; i < 6; i++) begin
            do_count($urandom_range(0, 66000));
            pace();
        end
        do_read(0);
        do_read(10'd511);
        do_read(10'h3FF);
        do_append($urandom, $urandom);
        pace();
        do_read(10'h3FF);
        do_append($urandom, $urandom);
        do_count($urandom_range(0, 66000));
        pace();
        do_read(10'h3FF);
        do_read(ENTRY_W'($urandom_range(0, TABLE_DEPTH - 1)));
        do_clear();
        do_read(0);
        do_append(32'd7, 32'd9);
        do_read(0);
        gaps_on = 1'b0;
    endtask

    // Mostly well-formed traffic around a focal region, with noise mixed in
    task automatic test_random();
        bit [PAD_W-1:0]      pads [RAND_PHASES];
        pihc_pkg::t_cmd_beat b;
        bit [31:0]           focus, s;
        longint              p;
        int unsigned         pick, n;
        pads[0] = '0;
        pads[1] = PAD_MAX;
        pads[2] = PAD_W'($urandom_range(0, 4095));
        pads[3] = 20'd1;
        pads[4] = PAD_W'($urandom);
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_padding(pads[ph]);
            gaps_on    = (ph != 2);
            burst_left = $urandom_range(1, 40);
            focus = (ph == 3) ? 32'hFFFF_C000 : ((ph == 1) ? 32'd0 : $urandom);
            do_clear();
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                b    = noise_beat();
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    b.command = pihc_pkg::CMD_CLEAR;
                end else if (pick < 28) begin
                    b.command = pihc_pkg::CMD_APPEND;
                    if ($urandom_range(0, 7) != 0) begin
                        s = focus + $urandom_range(0, 8192);
                        b.interval_start = s;
                        b.interval_end = ($urandom_range(0, 9) == 0) ?
                                         s - $urandom_range(1, 64) : s + $urandom_range(0, 2048);
                    end
                end else if (pick < 68) begin
                    b.command = pihc_pkg::CMD_COUNT;
                    if (shadow_fill > 0 && $urandom_range(0, 3) != 0) begin
                        // Aim at the padded bounds of a loaded entry
                        n = $urandom_range(0, shadow_fill - 1);
                        p = $urandom_range(0, 1) ?
                            longint'({32'd0, shadow_start[n]}) - longint'(shadow_pad) :
                            longint'({32'd0, shadow_end[n]}) + longint'(shadow_pad);
                        p = p + $urandom_range(0, 4) - 2;
                        b.read_position = p[31:0];
                    end else if ($urandom_range(0, 3) != 0) begin
                        b.read_position = focus + $urandom_range(0, 10240);
                    end
                end else begin
                    b.command = pihc_pkg::CMD_READ;
                    if (shadow_fill > 0 && $urandom_range(0, 7) != 0)
                        b.entry_index = ENTRY_W'($urandom_range(0, shadow_fill - 1));
                end
                send_beat(b);
                pace();
            end
        end
        gaps_on = 1'b0;
    endtask

    initial begin
        shadow_fill = 0;
        shadow_ovf  = 1'b0;
        shadow_pad  = '0;
        gaps_on     = 1'b0;
        burst_left  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_padding_edges();
        test_full_table();
        test_random();
        wait_idle();

        if (pending_reads.size() != 0)
            mismatches += pending_reads.size();
        $display("Run covered %0d commands and %0d padding writes; %0d reads checked",
                 beats_sent, pad_writes, reads_checked);
        $display("  (%0d on loaded entries, %0d with overflow set), %0d mismatches",
                 valid_reads, ovf_reads, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // End the run if it hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout: %0d reads still pending", pending_reads.size());
        $display("FAIL");
        $finish;
    end

endmodule
